[src/sic_pkg.sv]
// shared types, widths and constants for the segment intersection centroid block
package sic_pkg;

	localparam int MaxLinesDef = 8;

	localparam int CrdW  = 10;
	localparam int DifW  = 12;
	localparam int PrdW  = 24;
	localparam int SdenW = 26;
	localparam int NumW  = 40;
	localparam int DenW  = 24;
	localparam int DvdW  = 44;
	localparam int QuoW  = 20;
	localparam int SumW  = 20;
	localparam int KeptW = 6;
	localparam int PtW   = 16;
	localparam int OffW  = 11;
	localparam int CfgW  = 11;
	localparam int CfgIdxW = 2;
	localparam int SegW  = 4 * CrdW;

	localparam logic [CfgIdxW-1:0] RegMaxCoord = 2'd0;
	localparam logic [CfgIdxW-1:0] RegOffsetX  = 2'd1;
	localparam logic [CfgIdxW-1:0] RegOffsetY  = 2'd2;

	localparam logic [CrdW-1:0] MaxCoordRst = 10'd600;
	localparam logic [OffW-1:0] OffsetXRst  = 11'd674;
	localparam logic [OffW-1:0] OffsetYRst  = 11'd368;

	localparam logic KindCross    = 1'b0;
	localparam logic KindCentroid = 1'b1;

	typedef struct packed {
		logic [CrdW-1:0] x0;
		logic [CrdW-1:0] y0;
		logic [CrdW-1:0] x1;
		logic [CrdW-1:0] y1;
	} seg_t;

	typedef struct packed {
		logic            done;
		logic            keep;
		logic [NumW-1:0] xn;
		logic [DenW-1:0] xd;
		logic [NumW-1:0] yn;
		logic [DenW-1:0] yd;
	} geo_res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_RD_I,
		S_RD_J,
		S_LAT_J,
		S_GEOM,
		S_DIVX,
		S_DIVY,
		S_EMIT,
		S_NEXT,
		S_CENT,
		S_CDIVX,
		S_CDIVY,
		S_CEMIT
	} state_t;

endpackage

[src/sic_div.sv]
// iterative restoring divider, one quotient bit per cycle
module sic_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [sic_pkg::DvdW-1:0] dividend,
	input  logic [sic_pkg::DenW-1:0] divisor,
	output logic                     done,
	output logic [sic_pkg::QuoW-1:0] quotient
);
	import sic_pkg::*;

	localparam int CntW = $clog2(QuoW);

	logic            busy_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [DvdW-1:0] rem_q;
	logic [DvdW-1:0] den_q;
	logic [QuoW-1:0] quo_q;
	logic [DvdW-1:0] trial;

	assign trial = den_q << cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(QuoW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			den_q <= DvdW'(divisor);
			quo_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q        <= rem_q - trial;
				quo_q[cnt_q] <= 1'b1;
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[src/sic_isect.sv]
// pipelined exact line crossing with range check
module sic_isect (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  sic_pkg::seg_t            seg_a,
	input  sic_pkg::seg_t            seg_b,
	input  logic [sic_pkg::CrdW-1:0] max_coord,
	output sic_pkg::geo_res_t        res
);
	import sic_pkg::*;

	logic [5:0] v_q;

	// stage 1
	logic                   va_s1, vb_s1;
	logic [CrdW-1:0]        a0_s1, a1_s1, b0_s1, b1_s1;
	logic signed [DifW-1:0] dx1_s1, dy1_s1, dx2_s1, dy2_s1, ba0_s1, ba1_s1;
	// stage 2
	logic                   va_s2, vb_s2;
	logic [CrdW-1:0]        a0_s2, a1_s2, b0_s2;
	logic signed [DifW-1:0] dx1_s2, dy1_s2, dx2_s2;
	logic signed [PrdW-1:0] pd1_s2, pd2_s2, pt1_s2, pt2_s2, pva_s2, pvb1_s2, pvb2_s2;
	// stage 3
	logic                    va_s3, vb_s3;
	logic [CrdW-1:0]         a0_s3, a1_s3, b0_s3;
	logic signed [DifW-1:0]  dx1_s3, dy1_s3, dx2_s3;
	logic signed [SdenW-1:0] d_s3, t_s3, yva_s3, yvb_s3;
	// stage 4
	logic                    ex_s4;
	logic signed [NumW-1:0]  xn_s4, yn_s4;
	logic signed [SdenW-1:0] xd_s4, yd_s4;
	// stage 5
	logic                    ex_s5;
	logic signed [NumW-1:0]  xn_s5, yn_s5;
	logic [DenW-1:0]         xd_s5, yd_s5;
	// stage 6
	logic                    keep_s6;
	logic [NumW-1:0]         xn_s6, yn_s6;
	logic [DenW-1:0]         xd_s6, yd_s6;

	logic signed [NumW-1:0]  xn_gen, yn_gen;
	logic [NumW-1:0]         lim_x, lim_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[4:0], start};
		end
	end

	assign xn_gen = NumW'($signed({1'b0, a0_s3}) * d_s3) + NumW'(t_s3 * dx1_s3);
	assign yn_gen = NumW'($signed({1'b0, a1_s3}) * d_s3) + NumW'(t_s3 * dy1_s3);
	assign lim_x  = NumW'(max_coord * xd_s5);
	assign lim_y  = NumW'(max_coord * yd_s5);

	always_ff @(posedge clk) begin
		va_s1  <= seg_a.x0 == seg_a.x1;
		vb_s1  <= seg_b.x0 == seg_b.x1;
		a0_s1  <= seg_a.x0;
		a1_s1  <= seg_a.y0;
		b0_s1  <= seg_b.x0;
		b1_s1  <= seg_b.y0;
		dx1_s1 <= $signed({2'b0, seg_a.x1}) - $signed({2'b0, seg_a.x0});
		dy1_s1 <= $signed({2'b0, seg_a.y1}) - $signed({2'b0, seg_a.y0});
		dx2_s1 <= $signed({2'b0, seg_b.x1}) - $signed({2'b0, seg_b.x0});
		dy2_s1 <= $signed({2'b0, seg_b.y1}) - $signed({2'b0, seg_b.y0});
		ba0_s1 <= $signed({2'b0, seg_b.x0}) - $signed({2'b0, seg_a.x0});
		ba1_s1 <= $signed({2'b0, seg_b.y0}) - $signed({2'b0, seg_a.y0});

		va_s2   <= va_s1;
		vb_s2   <= vb_s1;
		a0_s2   <= a0_s1;
		a1_s2   <= a1_s1;
		b0_s2   <= b0_s1;
		dx1_s2  <= dx1_s1;
		dy1_s2  <= dy1_s1;
		dx2_s2  <= dx2_s1;
		pd1_s2  <= dx1_s1 * dy2_s1;
		pd2_s2  <= dy1_s1 * dx2_s1;
		pt1_s2  <= ba0_s1 * dy2_s1;
		pt2_s2  <= ba1_s1 * dx2_s1;
		pva_s2  <= $signed({2'b0, b1_s1}) * dx2_s1;
		pvb1_s2 <= $signed({2'b0, a1_s1}) * dx1_s1;
		pvb2_s2 <= dy1_s1 * ba0_s1;

		va_s3  <= va_s2;
		vb_s3  <= vb_s2;
		a0_s3  <= a0_s2;
		a1_s3  <= a1_s2;
		b0_s3  <= b0_s2;
		dx1_s3 <= dx1_s2;
		dy1_s3 <= dy1_s2;
		dx2_s3 <= dx2_s2;
		d_s3   <= SdenW'(pd1_s2) - SdenW'(pd2_s2);
		t_s3   <= SdenW'(pt1_s2) - SdenW'(pt2_s2);
		yva_s3 <= SdenW'(pva_s2) - SdenW'(pt1_s2);
		yvb_s3 <= SdenW'(pvb1_s2) + SdenW'(pvb2_s2);

		if (va_s3) begin
			ex_s4 <= !vb_s3;
			xn_s4 <= NumW'($signed({1'b0, a0_s3}));
			xd_s4 <= SdenW'(1);
			yn_s4 <= NumW'(yva_s3);
			yd_s4 <= SdenW'(dx2_s3);
		end else if (vb_s3) begin
			ex_s4 <= 1'b1;
			xn_s4 <= NumW'($signed({1'b0, b0_s3}));
			xd_s4 <= SdenW'(1);
			yn_s4 <= NumW'(yvb_s3);
			yd_s4 <= SdenW'(dx1_s3);
		end else begin
			ex_s4 <= d_s3 != '0;
			xn_s4 <= xn_gen;
			xd_s4 <= d_s3;
			yn_s4 <= yn_gen;
			yd_s4 <= d_s3;
		end

		ex_s5 <= ex_s4;
		xn_s5 <= xd_s4[SdenW-1] ? -xn_s4 : xn_s4;
		xd_s5 <= DenW'(xd_s4[SdenW-1] ? -xd_s4 : xd_s4);
		yn_s5 <= yd_s4[SdenW-1] ? -yn_s4 : yn_s4;
		yd_s5 <= DenW'(yd_s4[SdenW-1] ? -yd_s4 : yd_s4);

		keep_s6 <= ex_s5 && (xn_s5 > 0) && ($unsigned(xn_s5) < lim_x)
			&& (yn_s5 > 0) && ($unsigned(yn_s5) < lim_y);
		xn_s6 <= $unsigned(xn_s5);
		xd_s6 <= xd_s5;
		yn_s6 <= $unsigned(yn_s5);
		yd_s6 <= yd_s5;
	end

	always_comb begin
		res.done = v_q[5];
		res.keep = keep_s6;
		res.xn   = xn_s6;
		res.xd   = xd_s6;
		res.yn   = yn_s6;
		res.yd   = yd_s6;
	end

endmodule

[src/segment_intersection_centroid.sv]
// top level: segment memory, pair sequencer, divider and output register
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | x_start y_start x_end y_end last_line
// out     | output    | out_valid/out_stall | kind point_x point_y found_count last_result
// cfg     | input     | cfg_we              | cfg_index cfg_data
//
// segments without last_line are taken back to back while the block is idle
// each pair is read and checked; a kept crossing is divided for x, then y, and emitted
// the centroid uses the same divider, skipped with no crossing; no input is taken during a run
// reset clears counts, sums and registers to their defaults; the segment memory is not cleared
// out_stall holds the run at its next result; in_stall is high for the whole run
module segment_intersection_centroid #(
	parameter int MAX_LINES = sic_pkg::MaxLinesDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [sic_pkg::CrdW-1:0]    x_start,
	input  logic [sic_pkg::CrdW-1:0]    y_start,
	input  logic [sic_pkg::CrdW-1:0]    x_end,
	input  logic [sic_pkg::CrdW-1:0]    y_end,
	input  logic                        last_line,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        kind,
	output logic [sic_pkg::PtW-1:0]     point_x,
	output logic [sic_pkg::PtW-1:0]     point_y,
	output logic [sic_pkg::KeptW-1:0]   found_count,
	output logic                        last_result,
	input  logic                        cfg_we,
	input  logic [sic_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [sic_pkg::CfgW-1:0]    cfg_data
);
	import sic_pkg::*;

	localparam int IdxW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int CntW = $clog2(MAX_LINES + 1);

	state_t state_q, state_d;

	seg_t            seg_mem [MAX_LINES];
	seg_t            rd_data_q;
	logic [IdxW-1:0] rd_addr;
	seg_t            seg_a_q;

	logic [CntW-1:0]  count_q;
	logic [IdxW-1:0]  pi_q, pj_q;
	logic [SumW-1:0]  sum_x_q, sum_y_q;
	logic [KeptW-1:0] kept_q;
	logic [CrdW-1:0]  max_coord_q;
	logic [OffW-1:0]  offset_x_q, offset_y_q;

	geo_res_t         geo;
	geo_res_t         geo_q;
	logic [QuoW-1:0]  fx_q, fy_q;

	logic             div_start, div_done;
	logic [DvdW-1:0]  div_dvd;
	logic [DenW-1:0]  div_dvs;
	logic [QuoW-1:0]  div_quo;

	logic             out_valid_q, out_kind_q, out_last_q;
	logic [PtW-1:0]   out_x_q, out_y_q;
	logic [KeptW-1:0] out_cnt_q;

	logic in_acc, out_free, mem_we;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign out_free = !out_valid_q || !out_stall;
	assign mem_we   = in_acc && (count_q < CntW'(MAX_LINES));

	sic_isect u_isect (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == S_LAT_J),
		.seg_a     (seg_a_q),
		.seg_b     (rd_data_q),
		.max_coord (max_coord_q),
		.res       (geo)
	);

	sic_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// segment memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			seg_mem[count_q[IdxW-1:0]] <= '{x_start, y_start, x_end, y_end};
		end
		rd_data_q <= seg_mem[rd_addr];
	end

	always_comb begin
		rd_addr   = (state_q == S_RD_I) ? pi_q : pj_q;
		div_start = 1'b0;
		div_dvd   = {geo.xn, 4'b0};
		div_dvs   = geo.xd;
		state_d   = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && last_line) begin
					state_d = S_START;
				end
			end
			S_START: begin
				state_d = (count_q < CntW'(2)) ? S_CENT : S_RD_I;
			end
			S_RD_I:  state_d = S_RD_J;
			S_RD_J:  state_d = S_LAT_J;
			S_LAT_J: state_d = S_GEOM;
			S_GEOM: begin
				if (geo.done) begin
					div_start = geo.keep;
					state_d   = geo.keep ? S_DIVX : S_NEXT;
				end
			end
			S_DIVX: begin
				div_dvd = {geo_q.yn, 4'b0};
				div_dvs = geo_q.yd;
				if (div_done) begin
					div_start = 1'b1;
					state_d   = S_DIVY;
				end
			end
			S_DIVY: begin
				if (div_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = S_NEXT;
				end
			end
			S_NEXT: begin
				if ((CntW'(pj_q) + 1'b1) < count_q) begin
					state_d = S_RD_I;
				end else if ((CntW'(pi_q) + CntW'(2)) < count_q) begin
					state_d = S_RD_I;
				end else begin
					state_d = S_CENT;
				end
			end
			S_CENT: begin
				div_dvd = DvdW'(sum_x_q);
				div_dvs = DenW'(kept_q);
				if (kept_q != '0) begin
					div_start = 1'b1;
					state_d   = S_CDIVX;
				end else begin
					state_d = S_CEMIT;
				end
			end
			S_CDIVX: begin
				div_dvd = DvdW'(sum_y_q);
				div_dvs = DenW'(kept_q);
				if (div_done) begin
					div_start = 1'b1;
					state_d   = S_CDIVY;
				end
			end
			S_CDIVY: begin
				if (div_done) begin
					state_d = S_CEMIT;
				end
			end
			S_CEMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pi_q        <= '0;
			pj_q        <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			kept_q      <= '0;
			max_coord_q <= MaxCoordRst;
			offset_x_q  <= OffsetXRst;
			offset_y_q  <= OffsetYRst;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					RegMaxCoord: max_coord_q <= cfg_data[CrdW-1:0];
					RegOffsetX:  offset_x_q  <= cfg_data[OffW-1:0];
					RegOffsetY:  offset_y_q  <= cfg_data[OffW-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (mem_we) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_START) begin
				pi_q <= '0;
				pj_q <= IdxW'(1);
			end
			if (state_q == S_NEXT) begin
				if ((CntW'(pj_q) + 1'b1) < count_q) begin
					pj_q <= pj_q + 1'b1;
				end else begin
					pi_q <= pi_q + 1'b1;
					pj_q <= pi_q + IdxW'(2);
				end
			end
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
				sum_x_q     <= sum_x_q + SumW'(fx_q);
				sum_y_q     <= sum_y_q + SumW'(fy_q);
				kept_q      <= kept_q + 1'b1;
			end
			if (state_q == S_CEMIT && out_free) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				sum_x_q     <= '0;
				sum_y_q     <= '0;
				kept_q      <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD_J) begin
			seg_a_q <= rd_data_q;
		end
		if (state_q == S_GEOM && geo.done) begin
			geo_q <= geo;
		end
		if (state_q == S_CENT) begin
			fx_q <= '0;
			fy_q <= '0;
		end
		if ((state_q == S_DIVX || state_q == S_CDIVX) && div_done) begin
			fx_q <= div_quo;
		end
		if ((state_q == S_DIVY || state_q == S_CDIVY) && div_done) begin
			fy_q <= div_quo;
		end
		if (state_q == S_EMIT && out_free) begin
			out_kind_q <= KindCross;
			out_last_q <= 1'b0;
			out_x_q    <= fx_q[PtW-1:0];
			out_y_q    <= fy_q[PtW-1:0];
			out_cnt_q  <= kept_q + 1'b1;
		end
		if (state_q == S_CEMIT && out_free) begin
			out_kind_q <= KindCentroid;
			out_last_q <= 1'b1;
			out_x_q    <= PtW'({offset_x_q, 4'b0}) + fx_q[PtW-1:0];
			out_y_q    <= PtW'({offset_y_q, 4'b0}) + fy_q[PtW-1:0];
			out_cnt_q  <= kept_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_kind_q;
	assign point_x     = out_x_q;
	assign point_y     = out_y_q;
	assign found_count = out_cnt_q;
	assign last_result = out_last_q;

endmodule

[src/sic_check.sv]
// port-level checks for the segment intersection centroid block
module sic_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        last_line,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        kind,
	input logic [sic_pkg::KeptW-1:0]   found_count,
	input logic                        last_result
);
	import sic_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == last_result))
		else $error("centroid flag and kind disagree");

	a_cross_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KindCross) |-> found_count != '0)
		else $error("crossing item with zero count");

	a_run_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_line |=> in_stall)
		else $error("input taken during a run");

endmodule

bind segment_intersection_centroid sic_check u_sic_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.last_line   (last_line),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.kind        (kind),
	.found_count (found_count),
	.last_result (last_result)
);

[test/segment_intersection_centroid_tb.sv]
// testbench for the segment intersection centroid block with its own crossing and centroid predictor
module segment_intersection_centroid_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sic_pkg::*;

	typedef struct {
		logic            kind;
		logic [PtW-1:0]  px;
		logic [PtW-1:0]  py;
		logic [KeptW-1:0] cnt;
		logic            last;
	} point_t;

	class centroid_board;
		seg_t   segs[$];
		point_t pending[$];
		int     errors;
		int     mc;
		int     ox;
		int     oy;

		function void set_reg(logic [CfgIdxW-1:0] idx, int v);
			case (idx)
				RegMaxCoord: mc = v & 'h3ff;
				RegOffsetX:  ox = v & 'h7ff;
				RegOffsetY:  oy = v & 'h7ff;
				default: ;
			endcase
		endfunction

		function bit in_range(longint n, longint d);
			return n > 0 && n < longint'(mc) * d;
		endfunction

		function void note_segment(seg_t s, logic lst);
			longint a0, a1, a2, a3, b0, b1, b2, b3, xn, xd, yn, yd, d, t;
			longint sx, sy, fx, fy, cx, cy;
			int k;
			point_t p;
			bit ok;
			if (segs.size() < MaxLinesDef) segs.insert(segs.size(), s);
			if (!lst) return;
			sx = 0; sy = 0; k = 0;
			for (int i = 0; i < segs.size(); i++) begin
				for (int j = i + 1; j < segs.size(); j++) begin
					a0 = segs[i].x0; a1 = segs[i].y0; a2 = segs[i].x1; a3 = segs[i].y1;
					b0 = segs[j].x0; b1 = segs[j].y0; b2 = segs[j].x1; b3 = segs[j].y1;
					ok = 1;
					if (a0 == a2) begin
						if (b0 == b2) ok = 0;
						xn = a0; xd = 1;
						yn = b1 * (b2 - b0) + (b3 - b1) * (a0 - b0); yd = b2 - b0;
					end else if (b0 == b2) begin
						xn = b0; xd = 1;
						yn = a1 * (a2 - a0) + (a3 - a1) * (b0 - a0); yd = a2 - a0;
					end else begin
						d = (a2 - a0) * (b3 - b1) - (a3 - a1) * (b2 - b0);
						if (d == 0) ok = 0;
						t = (b0 - a0) * (b3 - b1) - (b1 - a1) * (b2 - b0);
						xn = a0 * d + t * (a2 - a0); xd = d;
						yn = a1 * d + t * (a3 - a1); yd = d;
					end
					if (!ok) continue;
					if (xd < 0) begin xn = -xn; xd = -xd; end
					if (yd < 0) begin yn = -yn; yd = -yd; end
					if (!in_range(xn, xd) || !in_range(yn, yd)) continue;
					fx = (xn * 16) / xd;
					fy = (yn * 16) / yd;
					sx = (sx + fx) & 'hfffff;
					sy = (sy + fy) & 'hfffff;
					k++;
					p.kind = KindCross; p.px = fx[15:0]; p.py = fy[15:0];
					p.cnt = k[5:0]; p.last = 0;
					pending.insert(pending.size(), p);
				end
			end
			cx = ox * 16; cy = oy * 16;
			if (k != 0) begin
				cx += sx / k;
				cy += sy / k;
			end
			p.kind = KindCentroid; p.px = cx[15:0]; p.py = cy[15:0];
			p.cnt = k[5:0]; p.last = 1;
			pending.insert(pending.size(), p);
			segs.delete();
		endfunction

		function void check_point(point_t got);
			point_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result x=%0d y=%0d", $time, got.px, got.py);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.kind !== e.kind || got.px !== e.px || got.py !== e.py ||
					got.cnt !== e.cnt || got.last !== e.last) begin
				$display("%0t mismatch expected k=%0d x=%0d y=%0d n=%0d l=%0d got k=%0d x=%0d y=%0d n=%0d l=%0d",
					$time, e.kind, e.px, e.py, e.cnt, e.last,
					got.kind, got.px, got.py, got.cnt, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, last_line;
	logic [CrdW-1:0] x_start, y_start, x_end, y_end;
	logic out_valid, out_stall, kind, last_result;
	logic [PtW-1:0] point_x, point_y;
	logic [KeptW-1:0] found_count;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgW-1:0] cfg_data;

	centroid_board board;
	int cycles;
	int burst;
	int stall_mode;

	segment_intersection_centroid u_dut (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver stall pattern and result check
	always @(posedge clk) begin
		point_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.kind = kind; got.px = point_x; got.py = point_y;
			got.cnt = found_count; got.last = last_result;
			board.check_point(got);
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
		if ($urandom_range(0, 60) == 0) stall_mode <= $urandom_range(0, 2);
	end

	task automatic write_reg(logic [CfgIdxW-1:0] idx, int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[CfgW-1:0];
		board.set_reg(idx, v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		if (burst != 0) begin
			burst = 0;
			in_valid <= 1'b0;
		end
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_segment(int xs, int ys, int xe, int ye, bit lst);
		seg_t s;
		if (burst == 0) begin
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst = $urandom_range(1, 10);
		end
		burst--;
		s.x0 = CrdW'(xs); s.y0 = CrdW'(ys); s.x1 = CrdW'(xe); s.y1 = CrdW'(ye);
		in_valid <= 1'b1;
		x_start <= s.x0; y_start <= s.y0; x_end <= s.x1; y_end <= s.y1;
		last_line <= lst;
		do @(posedge clk); while (in_stall);
		board.note_segment(s, lst);
		if (burst == 0) in_valid <= 1'b0;
	endtask

	task automatic random_set(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				int v;
				v = $urandom_range(0, 1023);
				send_segment(v, $urandom_range(0, 1023), v, $urandom_range(0, 1023), i == n - 1);
			end else if ($urandom_range(0, 5) == 0) begin
				int v;
				v = $urandom_range(0, 1023);
				send_segment($urandom_range(0, 1023), v, $urandom_range(0, 1023), v, i == n - 1);
			end else if ($urandom_range(0, 1)) begin
				send_segment($urandom_range(0, 700), $urandom_range(0, 700),
					$urandom_range(0, 700), $urandom_range(0, 700), i == n - 1);
			end else begin
				send_segment($urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 1023), i == n - 1);
			end
		end
	endtask

	initial begin
		int sent;
		board = new();
		board.mc = 600; board.ox = 674; board.oy = 368;
		cycles = 0; burst = 0; stall_mode = 0;
		arst_n = 1'b0;
		in_valid = 1'b0; last_line = 1'b0;
		x_start = '0; y_start = '0; x_end = '0; y_end = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0; cfg_index = RegMaxCoord; cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, verticals, horizontals, parallel, points, extremes
		send_segment(100, 0, 100, 500, 0);
		send_segment(300, 10, 300, 900, 0);
		send_segment(0, 200, 1023, 200, 0);
		send_segment(0, 0, 400, 400, 0);
		send_segment(0, 100, 400, 500, 0);
		send_segment(50, 50, 50, 50, 0);
		send_segment(1023, 0, 0, 1023, 0);
		send_segment(0, 1023, 1023, 0, 1);
		send_segment(5, 5, 9, 9, 1);
		drain();
		write_reg(RegMaxCoord, 1023);
		write_reg(RegOffsetX, 2047);
		write_reg(RegOffsetY, 0);
		send_segment(1023, 1023, 0, 0, 0);
		send_segment(0, 1023, 1023, 1, 0);
		send_segment(1022, 0, 1022, 1023, 0);
		send_segment(0, 1022, 1023, 1022, 0);
		send_segment(1, 0, 1, 1023, 0);
		send_segment(0, 1, 1023, 1, 0);
		send_segment(512, 0, 511, 1023, 0);
		send_segment(0, 511, 1023, 512, 0);
		send_segment(7, 7, 900, 901, 0);
		send_segment(100, 200, 300, 400, 1);
		drain();
		write_reg(RegMaxCoord, 1);
		write_reg(RegOffsetX, 0);
		write_reg(RegOffsetY, 2047);
		send_segment(0, 0, 2, 2, 0);
		send_segment(0, 2, 2, 0, 1);
		drain();
		write_reg(RegMaxCoord, 0);
		send_segment(0, 0, 2, 2, 0);
		send_segment(0, 2, 2, 0, 1);
		drain();

		sent = 23;
		while (sent < 160) begin
			if ($urandom_range(0, 4) == 0) begin
				drain();
				write_reg(RegMaxCoord, $urandom_range(0, 2) == 0 ? 1023 : $urandom_range(1, 1023));
				write_reg(RegOffsetX, $urandom_range(0, 2047));
				write_reg(RegOffsetY, $urandom_range(0, 2047));
			end
			begin
				int n;
				n = $urandom_range(0, 3) == 0 ? $urandom_range(9, 11) : $urandom_range(1, 8);
				random_set(n);
				sent += n;
			end
		end
		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
